// ----- rtl/core/upm_pkg.sv -----
// Shared constants and types for the alpha unpremultiply pipeline.
package upm_pkg;

   localparam int CH_W          = 8;
   localparam int PIXEL_W       = 4 * CH_W;
   localparam int NUM_COLORS    = 3;
   localparam int QUOT_W        = 2 * CH_W;
   localparam int ACC_W         = CH_W + QUOT_W;
   localparam int DIV_STAGES    = 4;
   localparam int STEPS_PER_STG = QUOT_W / DIV_STAGES;

   localparam logic [CH_W-1:0] ALPHA_ZERO = '0;

   typedef logic [CH_W-1:0]    chan_type;
   typedef logic [PIXEL_W-1:0] pixel_type;
   typedef logic [ACC_W-1:0]   acc_type;

endpackage

// ----- rtl/core/upm_div_stage.sv -----
// One registered stage of the restoring divider, producing several quotient bits.
module upm_div_stage (
   input  logic             clock,
   input  logic             load,
   input  upm_pkg::chan_type divisor,
   input  upm_pkg::acc_type  acc_in,
   output upm_pkg::acc_type  acc_out
);
   import upm_pkg::*;

   acc_type acc_ff;
   acc_type acc_next_in;

   always_comb begin
      acc_type     work;
      logic [CH_W:0] top;
      work = acc_in;
      for (int i = 0; i < STEPS_PER_STG; i++) begin
         top = {work[ACC_W-1:QUOT_W], work[QUOT_W-1]};
         if (top >= {1'b0, divisor}) begin
            top  = top - {1'b0, divisor};
            work = {top[CH_W-1:0], work[QUOT_W-2:0], 1'b1};
         end else begin
            work = {top[CH_W-1:0], work[QUOT_W-2:0], 1'b0};
         end
      end
      acc_next_in = work;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         acc_ff <= acc_next_in;
      end
   end

   assign acc_out = acc_ff;

endmodule

// ----- rtl/core/unpremultiply_argb_to_rgba.sv -----
// Top level of the premultiplied ARGB to straight-alpha RGBA pixel converter.
// An accepted transaction enters the first of four divider stages, moves through
// the rest in order, and the output register follows the last stage.
// Throughput: one pixel per cycle while the result channel does not stall;
// each color channel has its own divider pipeline.
// Reset clears all valid bits and sets the packing register to little-endian.
module unpremultiply_argb_to_rgba (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  upm_pkg::pixel_type req_pixel_in,
   input  logic               req_last_in,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output upm_pkg::pixel_type rsp_pixel_out,
   output logic               rsp_last_out,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_big_endian_packing
);
   import upm_pkg::*;

   logic      big_endian_ff;
   logic      valid_ff [DIV_STAGES];
   pixel_type pix_ff   [DIV_STAGES];
   logic      last_ff  [DIV_STAGES];
   logic      rdy      [DIV_STAGES+1];
   chan_type  alpha_d  [DIV_STAGES];
   acc_type   acc_d    [NUM_COLORS][DIV_STAGES];
   acc_type   acc_q    [NUM_COLORS][DIV_STAGES];

   logic      rsp_valid_ff;
   pixel_type rsp_pixel_ff;
   logic      rsp_last_ff;
   pixel_type rsp_pixel_in;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         big_endian_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         big_endian_ff <= csr_big_endian_packing;
      end
   end

   always_comb begin
      rdy[DIV_STAGES] = !rsp_valid_ff || !rsp_stall;
      for (int k = DIV_STAGES - 1; k >= 0; k--) begin
         rdy[k] = !valid_ff[k] || rdy[k+1];
      end
   end

   assign req_stall = !rdy[0];

   genvar st, ch;
   generate
      for (st = 0; st < DIV_STAGES; st++) begin : g_stage
         if (st == 0) begin : g_first
            assign alpha_d[st] = req_pixel_in[PIXEL_W-1 -: CH_W];
            always_ff @(posedge clock) begin
               if (reset) begin
                  valid_ff[st] <= 1'b0;
               end else if (rdy[st]) begin
                  valid_ff[st] <= req_valid;
               end
               if (rdy[st]) begin
                  pix_ff[st]  <= req_pixel_in;
                  last_ff[st] <= req_last_in;
               end
            end
         end else begin : g_next
            assign alpha_d[st] = pix_ff[st-1][PIXEL_W-1 -: CH_W];
            always_ff @(posedge clock) begin
               if (reset) begin
                  valid_ff[st] <= 1'b0;
               end else if (rdy[st]) begin
                  valid_ff[st] <= valid_ff[st-1];
               end
               if (rdy[st]) begin
                  pix_ff[st]  <= pix_ff[st-1];
                  last_ff[st] <= last_ff[st-1];
               end
            end
         end

         for (ch = 0; ch < NUM_COLORS; ch++) begin : g_chan
            if (st == 0) begin : g_init
               chan_type color;
               assign color = req_pixel_in[PIXEL_W-CH_W-1-CH_W*ch -: CH_W];
               assign acc_d[ch][st] = {{CH_W{1'b0}},
                  ({color, {CH_W{1'b0}}} - {{CH_W{1'b0}}, color})};
            end else begin : g_chain
               assign acc_d[ch][st] = acc_q[ch][st-1];
            end

            upm_div_stage u_div (
               .clock   (clock),
               .load    (rdy[st]),
               .divisor (alpha_d[st]),
               .acc_in  (acc_d[ch][st]),
               .acc_out (acc_q[ch][st])
            );
         end
      end
   endgenerate

   always_comb begin
      chan_type a, r, g, b;
      a = pix_ff[DIV_STAGES-1][PIXEL_W-1 -: CH_W];
      r = acc_q[0][DIV_STAGES-1][CH_W-1:0];
      g = acc_q[1][DIV_STAGES-1][CH_W-1:0];
      b = acc_q[2][DIV_STAGES-1][CH_W-1:0];
      if (a == ALPHA_ZERO) begin
         rsp_pixel_in = pix_ff[DIV_STAGES-1];
      end else if (big_endian_ff) begin
         rsp_pixel_in = {r, g, b, a};
      end else begin
         rsp_pixel_in = {a, b, g, r};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rdy[DIV_STAGES]) begin
         rsp_valid_ff <= valid_ff[DIV_STAGES-1];
      end
      if (rdy[DIV_STAGES]) begin
         rsp_pixel_ff <= rsp_pixel_in;
         rsp_last_ff  <= last_ff[DIV_STAGES-1];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel_out = rsp_pixel_ff;
   assign rsp_last_out  = rsp_last_ff;

endmodule
